/* hdl/pkhi_pkg.sv */
// Shared types and constants for the pointer key hash index.
// Used by pkhi_slot_store and pointer_key_hash_index_top; depends on nothing.
package pkhi_pkg;

  localparam int unsigned DEFAULT_SLOTS = 1024;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned ID_W  = 9;
  localparam int unsigned ST_W  = 3;

  // Hash: v = key >> 3; v ^= v >> 17; v *= HASH_MUL; v ^= v >> 11.
  localparam int unsigned PRE_SHIFT  = 3;
  localparam int unsigned XOR_SHIFT  = 17;
  localparam int unsigned POST_SHIFT = 11;
  localparam logic [31:0] HASH_MUL   = 32'hED5A_D4BB;

  typedef enum logic [ST_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_NULL      = 3'd4
  } status_e;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b000_0001,
    S_IDLE  = 7'b000_0010,
    S_HASH1 = 7'b000_0100,
    S_HASH2 = 7'b000_1000,
    S_READ  = 7'b001_0000,
    S_CMP   = 7'b010_0000,
    S_DONE  = 7'b100_0000
  } state_e;

  // Control of the slot store for one cycle.
  typedef struct packed {
    logic rd_en;     // read key, id and valid mark at the address
    logic wr_en;     // write key and id, set the valid mark
    logic wr_clear;  // clear the valid mark only
  } store_ctl_t;

endpackage

/* hdl/pointer_key_hash_index_top.sv */
// Pointer key hash index: maps nonzero 64-bit keys to dense ids by linear probing.
// A request runs through S_HASH1 and S_HASH2, then S_READ and S_CMP for each probe, then S_DONE;
// a null key goes straight to S_DONE. No new request is accepted until the result is registered.
// Each probe is split into S_READ and S_CMP by the single registered read port of the slot store.
// After reset a clearing pass sweeps the valid marks; requests stall meanwhile.
// Depends on pkhi_pkg and pkhi_slot_store.
module pointer_key_hash_index_top #(
  parameter int unsigned SLOTS = pkhi_pkg::DEFAULT_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [pkhi_pkg::KEY_W-1:0] key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pkhi_pkg::ID_W-1:0]  node_id_o,
  output logic [pkhi_pkg::ST_W-1:0]  status_o
);

  localparam int unsigned SW = $clog2(SLOTS);

  pkhi_pkg::state_e state_q, state_d;

  logic                       mode_q;
  logic [pkhi_pkg::KEY_W-1:0] key_q;
  logic [31:0]                prod_q, prod_d;
  logic [SW-1:0]              slot_q, slot_d;
  logic [SW-1:0]              clr_q, clr_d;
  logic [SW-1:0]              count_q, count_d;
  logic [pkhi_pkg::ID_W-1:0]  res_id_q, res_id_d;
  pkhi_pkg::status_e          res_st_q, res_st_d;
  logic                       out_valid_q, out_valid_d;
  logic [pkhi_pkg::ID_W-1:0]  node_id_q;
  logic [pkhi_pkg::ST_W-1:0]  status_q;

  pkhi_pkg::store_ctl_t       ctl;
  logic [SW-1:0]              store_addr;
  logic [pkhi_pkg::KEY_W-1:0] rd_key;
  logic [pkhi_pkg::ID_W-1:0]  rd_id;
  logic                       rd_valid;

  logic                       in_accept;
  logic                       out_free;
  logic                       table_full;
  logic [pkhi_pkg::ID_W-1:0]  id_new;
  logic [pkhi_pkg::KEY_W-1:0] pre_v;
  logic [31:0]                hash_x;
  logic [31:0]                hash_h;

  assign in_stall_o = (state_q != pkhi_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The output register may be loaded when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Only the low 32 bits of the 64-bit product reach the slot index (index plus the
  // post shift is 21 bits for the default 1024 slots), so the upper partial product never
  // matters and one 32 by 32 multiply suffices.
  assign pre_v  = key_q >> pkhi_pkg::PRE_SHIFT;
  assign hash_x = pre_v[31:0] ^ pre_v[pkhi_pkg::XOR_SHIFT +: 32];
  assign prod_d = hash_x * pkhi_pkg::HASH_MUL;
  assign hash_h = prod_q ^ (prod_q >> pkhi_pkg::POST_SHIFT);

  // An insert that would pass half load is refused.
  assign table_full = (count_q >= SW'(SLOTS / 2));

  // The id handed out is the entry count, cut or widened to the id field.
  if (SW >= pkhi_pkg::ID_W) begin : g_id_cut
    assign id_new = count_q[pkhi_pkg::ID_W-1:0];
  end else begin : g_id_ext
    assign id_new = {{(pkhi_pkg::ID_W - SW){1'b0}}, count_q};
  end

  // Sequencer: clear sweep, hash in two steps, then read and compare one slot at a time.
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    clr_d       = clr_q;
    count_d     = count_q;
    res_id_d    = res_id_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl         = '0;
    store_addr  = slot_q;

    case (state_q)
      pkhi_pkg::S_CLEAR: begin
        ctl.wr_clear = 1'b1;
        store_addr   = clr_q;
        clr_d        = clr_q + SW'(1);
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = pkhi_pkg::S_IDLE;
        end
      end
      pkhi_pkg::S_IDLE: begin
        if (in_accept) begin
          if (key_i == '0) begin
            res_id_d = '0;
            res_st_d = pkhi_pkg::ST_NULL;
            state_d  = pkhi_pkg::S_DONE;
          end else begin
            state_d = pkhi_pkg::S_HASH1;
          end
        end
      end
      pkhi_pkg::S_HASH1: begin
        state_d = pkhi_pkg::S_HASH2;
      end
      pkhi_pkg::S_HASH2: begin
        slot_d  = hash_h[SW-1:0];
        state_d = pkhi_pkg::S_READ;
      end
      pkhi_pkg::S_READ: begin
        ctl.rd_en = 1'b1;
        state_d   = pkhi_pkg::S_CMP;
      end
      pkhi_pkg::S_CMP: begin
        state_d = pkhi_pkg::S_DONE;
        if (!rd_valid) begin
          // Free slot ends the walk: a miss, or the place for a new key.
          if (!mode_q) begin
            res_id_d = '0;
            res_st_d = pkhi_pkg::ST_NOT_FOUND;
          end else if (table_full) begin
            res_id_d = '0;
            res_st_d = pkhi_pkg::ST_FULL;
          end else begin
            ctl.wr_en = 1'b1;
            count_d   = count_q + SW'(1);
            res_id_d  = id_new;
            res_st_d  = pkhi_pkg::ST_INSERTED;
          end
        end else if (rd_key == key_q) begin
          res_id_d = rd_id;
          res_st_d = pkhi_pkg::ST_FOUND;
        end else begin
          // Occupied by another key: step to the next slot, wrapping round the table.
          slot_d  = slot_q + SW'(1);
          state_d = pkhi_pkg::S_READ;
        end
      end
      pkhi_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = pkhi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pkhi_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pkhi_pkg::S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      key_q  <= key_i;
    end
    prod_q   <= prod_d;
    slot_q   <= slot_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    if (state_q == pkhi_pkg::S_DONE && out_free) begin
      node_id_q <= res_id_q;
      status_q  <= res_st_q;
    end
  end

  pkhi_slot_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .addr_i     (store_addr),
    .wr_key_i   (key_q),
    .wr_id_i    (id_new),
    .rd_key_o   (rd_key),
    .rd_id_o    (rd_id),
    .rd_valid_o (rd_valid)
  );

  assign out_valid_o = out_valid_q;
  assign node_id_o   = node_id_q;
  assign status_o    = status_q;

endmodule

/* hdl/pkhi_slot_store.sv */
// Slot store of the hash index: key, id and valid-mark memories on one address.
// Depends on pkhi_pkg for widths and the store control struct.
module pkhi_slot_store #(
  parameter int unsigned SLOTS = pkhi_pkg::DEFAULT_SLOTS,
  localparam int unsigned SW   = $clog2(SLOTS)
) (
  input  logic                       clk_i,
  input  pkhi_pkg::store_ctl_t       ctl_i,
  input  logic [SW-1:0]              addr_i,
  input  logic [pkhi_pkg::KEY_W-1:0] wr_key_i,
  input  logic [pkhi_pkg::ID_W-1:0]  wr_id_i,
  output logic [pkhi_pkg::KEY_W-1:0] rd_key_o,
  output logic [pkhi_pkg::ID_W-1:0]  rd_id_o,
  output logic                       rd_valid_o
);

  logic [pkhi_pkg::KEY_W-1:0] key_mem [SLOTS];
  logic [pkhi_pkg::ID_W-1:0]  id_mem  [SLOTS];
  logic                       vld_mem [SLOTS];

  logic [pkhi_pkg::KEY_W-1:0] rd_key_q;
  logic [pkhi_pkg::ID_W-1:0]  rd_id_q;
  logic                       rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      key_mem[addr_i] <= wr_key_i;
      id_mem[addr_i]  <= wr_id_i;
    end
    if (ctl_i.rd_en) begin
      rd_key_q <= key_mem[addr_i];
      rd_id_q  <= id_mem[addr_i];
    end
  end

  // The valid marks are the only part swept clear after reset.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en || ctl_i.wr_clear) begin
      vld_mem[addr_i] <= ctl_i.wr_en;
    end
    if (ctl_i.rd_en) begin
      rd_valid_q <= vld_mem[addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_id_o    = rd_id_q;
  assign rd_valid_o = rd_valid_q;

endmodule

/* tb/key_index_checker.sv */
`timescale 1ns / 100ps
// Home-slot hash and request codes for the testbench, followed by the result checker.
// The checker mirrors the slot table and compares every result. Depends on pkhi_pkg.
package pkhi_tb_pkg;
  import pkhi_pkg::*;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  function automatic int unsigned key_home_slot(logic [KEY_W-1:0] key, int unsigned slots);
    logic [63:0] v;
    v = key >> PRE_SHIFT;
    v ^= v >> XOR_SHIFT;
    v = v * {32'd0, HASH_MUL};
    v ^= v >> POST_SHIFT;
    return v[31:0] & (slots - 1);
  endfunction

endpackage

module key_index_checker
  import pkhi_pkg::*;
  import pkhi_tb_pkg::*;
#(
  parameter int unsigned SLOTS = DEFAULT_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  logic              req_mode_i,
  input  logic [KEY_W-1:0]  req_key_i,
  input  logic              res_valid_i,
  input  logic              res_stall_i,
  input  logic [ID_W-1:0]   res_node_id_i,
  input  logic [ST_W-1:0]   res_status_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_count_o
);

  typedef struct packed {
    logic [ID_W-1:0] node_id;
    status_e         status;
  } index_result_t;

  // Mirror of the slot table; keys and ids are only read where the valid mark is set.
  logic [KEY_W-1:0] table_keys [SLOTS];
  logic [ID_W-1:0]  table_ids  [SLOTS];
  logic [SLOTS-1:0] table_valid;
  int unsigned      table_entries;

  index_result_t    awaited_results [$];
  int unsigned      result_number;

  task automatic note_failure(input string msg);
    if (mismatch_count_o < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatch_count_o++;
  endtask

  // Walks the probe chain from the home slot and applies an insert to the mirror.
  task automatic predict_index_result(input logic mode, input logic [KEY_W-1:0] key,
                                      output index_result_t res);
    int unsigned slot;
    int unsigned n;
    logic        hit;
    logic        free_found;
    res.node_id = '0;
    hit = 1'b0;
    free_found = 1'b0;
    if (key == '0) begin
      res.status = ST_NULL;
    end else begin
      slot = key_home_slot(key, SLOTS);
      for (n = 0; n < SLOTS && !hit && !free_found; n++) begin
        if (!table_valid[slot]) begin
          free_found = 1'b1;
        end else if (table_keys[slot] == key) begin
          hit = 1'b1;
          res.node_id = table_ids[slot];
        end else begin
          slot = (slot + 1) & (SLOTS - 1);
        end
      end
      if (hit) begin
        res.status = ST_FOUND;
      end else if (mode == MODE_LOOKUP) begin
        res.status = ST_NOT_FOUND;
      end else if (table_entries * 2 >= SLOTS || !free_found) begin
        res.status = ST_FULL;
      end else begin
        res.node_id = ID_W'(table_entries);
        res.status = ST_INSERTED;
        table_keys[slot] = key;
        table_ids[slot] = res.node_id;
        table_valid[slot] = 1'b1;
        table_entries++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    index_result_t want;
    if (!rst_ni) begin
      table_valid = '0;
      table_entries = 0;
      awaited_results.delete();
      result_number = 0;
      mismatch_count_o = 0;
      pending_count_o = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with none outstanding: id %0d status %0d",
                                 result_number, res_node_id_i, res_status_i));
        end else begin
          want = awaited_results.pop_front();
          if (res_node_id_i != want.node_id || res_status_i != want.status) begin
            note_failure($sformatf("result %0d: expected id %0d status %0d, got id %0d status %0d",
                                   result_number, want.node_id, want.status,
                                   res_node_id_i, res_status_i));
          end
        end
        result_number++;
      end
      if (req_valid_i && !req_stall_i) begin
        predict_index_result(req_mode_i, req_key_i, want);
        awaited_results.push_back(want);
      end
      pending_count_o = awaited_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the pointer key hash index testbench: clock, reset, request stimulus and verdict.
// Depends on pkhi_pkg, pkhi_tb_pkg, key_index_checker and pointer_key_hash_index_top.
module testbench;
  import pkhi_pkg::*;
  import pkhi_tb_pkg::*;

  localparam int unsigned SLOTS          = DEFAULT_SLOTS;
  localparam int unsigned RANDOM_ITEMS   = 725;
  // Enough new-key inserts to drive the table past half load, so that the
  // table full answer shows up many times in the random part.
  localparam int unsigned NEW_KEY_TARGET = 560;
  // The limit must cover the clearing pass after reset and a probe walk at half
  // load, which in the worst case covers up to 513 slots.
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             mode_i      = MODE_LOOKUP;
  logic [KEY_W-1:0] key_i       = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ID_W-1:0]  node_id_o;
  logic [ST_W-1:0]  status_o;

  int unsigned      mismatches;
  int unsigned      pending_results;

  always #5 clk_i = ~clk_i;

  pointer_key_hash_index_top #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .node_id_o  (node_id_o),
    .status_o   (status_o)
  );

  key_index_checker #(
    .SLOTS(SLOTS)
  ) index_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid_i),
    .req_stall_i     (in_stall_o),
    .req_mode_i      (mode_i),
    .req_key_i       (key_i),
    .res_valid_i     (out_valid_o),
    .res_stall_i     (out_stall_i),
    .res_node_id_i   (node_id_o),
    .res_status_i    (status_o),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending_results)
  );

  // Traffic alternates between calm stretches, where neither side idles, and
  // busy stretches with random gaps. The stretch lengths are random too, so
  // gaps land on every phase of a probe walk.
  logic        calm       = 1'b0;
  int unsigned calm_left  = 0;
  int unsigned stall_left = 0;

  // Gap length: mostly zero or short, now and then long.
  function automatic int unsigned pick_idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) begin
      return 0;
    end else if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Result side: stall segments of random length alternate with short runs; also times the calm stretches.
  always @(posedge clk_i) begin : drive_result_stall
    int unsigned hold;
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      hold = pick_idle_length();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= hold - 1;
      end
    end
  end

  // Watchdog: any cycle in which neither channel moves counts toward the limit.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request and holds it until accepted. Valid stays high after
  // acceptance, so a back-to-back request only replaces the payload.
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = pick_idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom}; while (k == '0);
    return k;
  endfunction

  // A key whose home slot is the given one, with the low three bits clear so
  // that its eight low-bit variants all share that home slot.
  function automatic logic [KEY_W-1:0] key_with_home(int unsigned slot);
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom} & ~64'h7;
    while (k == '0 || key_home_slot(k, SLOTS) != slot);
    return k;
  endfunction

  logic [KEY_W-1:0] known_keys [$];

  initial begin : stimulus
    logic [KEY_W-1:0] edge_key;
    logic [KEY_W-1:0] edge_miss;
    logic [KEY_W-1:0] k;
    int unsigned      issued;
    int unsigned      new_key_sends;
    int unsigned      r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Null key in both modes, then a miss, an insert, a repeated insert and a
    // hit on the all-ones key. The block stalls through its clearing pass.
    send_request(MODE_LOOKUP, '0);
    send_request(MODE_INSERT, '0);
    send_request(MODE_LOOKUP, '1);
    send_request(MODE_INSERT, '1);
    send_request(MODE_INSERT, '1);
    send_request(MODE_LOOKUP, '1);
    known_keys.push_back('1);

    // Keys 1 to 7 all hash to slot 0 and build a probe chain there.
    for (int i = 1; i < 8; i++) begin
      send_request(MODE_INSERT, KEY_W'(i));
      known_keys.push_back(KEY_W'(i));
    end
    send_request(MODE_LOOKUP, KEY_W'(8));

    // Eight keys homed at the last slot: the chain wraps round the end of the
    // table and has to walk past the chain at slot 0.
    edge_key = key_with_home(SLOTS - 1);
    do edge_miss = key_with_home(SLOTS - 1); while (edge_miss == edge_key);
    for (int i = 0; i < 8; i++) begin
      send_request(MODE_INSERT, edge_key | KEY_W'(i));
      known_keys.push_back(edge_key | KEY_W'(i));
    end
    send_request(MODE_LOOKUP, edge_key | KEY_W'(7));
    // A lookup miss that has to walk both chains before it finds a free slot.
    send_request(MODE_LOOKUP, edge_miss);

    // Random part: mostly inserts of new keys, some of them low-bit variants
    // of known keys so that home slots collide, mixed with repeated inserts,
    // hits, misses and null keys. It ends after RANDOM_ITEMS items and NEW_KEY_TARGET new-key inserts.
    issued = 0;
    new_key_sends = 0;
    while (issued < RANDOM_ITEMS || new_key_sends < NEW_KEY_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request($urandom_range(0, 1) ? MODE_INSERT : MODE_LOOKUP, '0);
      end else if (r < 83) begin
        if ($urandom_range(0, 4) == 0) begin
          k = known_keys[$urandom_range(0, known_keys.size() - 1)]
              ^ KEY_W'($urandom_range(1, 7));
          if (k == '0) begin
            k = KEY_W'(1);
          end
        end else begin
          k = fresh_key();
        end
        send_request(MODE_INSERT, k);
        known_keys.push_back(k);
        new_key_sends++;
      end else if (r < 88) begin
        send_request(MODE_INSERT, known_keys[$urandom_range(0, known_keys.size() - 1)]);
      end else if (r < 95) begin
        send_request(MODE_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)]);
      end else begin
        send_request(MODE_LOOKUP, fresh_key());
      end
      issued++;
    end
    in_valid_i <= 1'b0;

    // Let the checker register the last request, wait for every result, then
    // leave room for any stray result before the verdict.
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pkhi_pkg.sv
hdl/pkhi_slot_store.sv
hdl/pointer_key_hash_index_top.sv
tb/key_index_checker.sv
tb/testbench.sv
